>>> src/time_to_pseudo_float_encoder_defines.svh
// ---------------------------------------------------------------------------
// Time to pseudo-float encoder: assertion macros
// Shared assertion forms.  Each macro expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef TIME_TO_PSEUDO_FLOAT_ENCODER_DEFINES_SVH
`define TIME_TO_PSEUDO_FLOAT_ENCODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TPF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpf assertion failed");

`endif

>>> src/tpf_pkg.sv
// ---------------------------------------------------------------------------
// tpf_pkg
// Widths, constants and handoff types of the time to pseudo-float encoder.
// ---------------------------------------------------------------------------
package tpf_pkg;

    localparam int SEC_W        = 32;
    localparam int USEC_W       = 20;
    localparam int CODE_W       = 16;
    localparam int FRAC_BITS    = 13;
    localparam int EXP_FIELD_W  = CODE_W - FRAC_BITS;
    localparam int MAX_EXP      = (1 << EXP_FIELD_W) - 1;
    localparam int SHIFT_STEP   = 3;
    localparam int ROUND_POS    = 2;

    localparam int TICK_RATE    = 64;
    localparam int USEC_PER_SEC = 1000000;
    localparam int TICK_LEN     = USEC_PER_SEC / TICK_RATE;

    localparam int RATE_W       = $clog2(TICK_RATE + 1);
    localparam int TICKS_W      = SEC_W + RATE_W + 1;
    localparam int EXP_W        = $clog2((TICKS_W - FRAC_BITS) / SHIFT_STEP + 3);

    // Division by the tick length is a multiply by a rounded-up reciprocal.
    // With the shift at input width plus ceil(log2(length)) the quotient is
    // exact for every input value.
    localparam int LEN_LOG      = $clog2(TICK_LEN);
    localparam int RECIP_SHIFT  = USEC_W + LEN_LOG;
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SHIFT) + 64'(TICK_LEN) - 64'd1) / 64'(TICK_LEN);
    localparam int RECIP_W      = USEC_W + 2;
    localparam int MULB_W       = (RECIP_W > RATE_W) ? RECIP_W : RATE_W;
    localparam int MUL_W        = (SEC_W + MULB_W > RECIP_SHIFT + USEC_W) ?
                                  (SEC_W + MULB_W) : (RECIP_SHIFT + USEC_W);

    typedef struct packed {
        logic               done;
        logic [TICKS_W-1:0] ticks;
    } tpf_scale_res_t;

    typedef struct packed {
        logic              done;
        logic [CODE_W-1:0] code;
    } tpf_norm_res_t;

endpackage

>>> src/tpf_scale.sv
// ---------------------------------------------------------------------------
// tpf_scale
// Converts seconds and microseconds to a tick count through one shared
// multiplier: first the reciprocal multiply, then the seconds scaling.
// ---------------------------------------------------------------------------
module tpf_scale (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tpf_pkg::SEC_W-1:0]    seconds,
    input  logic [tpf_pkg::USEC_W-1:0]   microseconds,
    output tpf_pkg::tpf_scale_res_t      res
);
    import tpf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL_US,
        S_MUL_SEC,
        S_SUM
    } state_t;

    state_t              state_reg, state_next;
    logic [SEC_W-1:0]    secs_reg, secs_next;
    logic [USEC_W-1:0]   usecs_reg, usecs_next;
    logic [USEC_W-1:0]   quo_reg, quo_next;
    logic [MUL_W-1:0]    prod_reg, prod_next;
    logic [TICKS_W-1:0]  ticks_reg, ticks_next;
    logic                done_reg, done_next;

    logic [SEC_W-1:0]    mul_a;
    logic [MULB_W-1:0]   mul_b;
    logic [MUL_W-1:0]    mul_p;

    always_comb
    begin
        if (state_reg == S_MUL_US)
        begin
            mul_a = SEC_W'(usecs_reg);
            mul_b = MULB_W'(RECIP);
        end
        else
        begin
            mul_a = secs_reg;
            mul_b = MULB_W'(TICK_RATE);
        end
        mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);
    end

    always_comb
    begin
        state_next = state_reg;
        secs_next  = secs_reg;
        usecs_next = usecs_reg;
        quo_next   = quo_reg;
        prod_next  = prod_reg;
        ticks_next = ticks_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    secs_next  = seconds;
                    usecs_next = microseconds;
                    state_next = S_MUL_US;
                end
            end
            S_MUL_US:
            begin
                prod_next  = mul_p;
                state_next = S_MUL_SEC;
            end
            S_MUL_SEC:
            begin
                quo_next   = prod_reg[RECIP_SHIFT +: USEC_W];
                prod_next  = mul_p;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                ticks_next = prod_reg[TICKS_W-1:0] + TICKS_W'(quo_reg);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            secs_reg  <= '0;
            usecs_reg <= '0;
            quo_reg   <= '0;
            prod_reg  <= '0;
            ticks_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            secs_reg  <= secs_next;
            usecs_reg <= usecs_next;
            quo_reg   <= quo_next;
            prod_reg  <= prod_next;
            ticks_reg <= ticks_next;
        end
    end

    assign res.done  = done_reg;
    assign res.ticks = ticks_reg;

endmodule

>>> src/tpf_norm.sv
// ---------------------------------------------------------------------------
// tpf_norm
// Normalizes a tick count to a 13-bit fraction and base-8 exponent with a
// shift-by-three unit, one shift per cycle, then rounds and saturates.
// ---------------------------------------------------------------------------
`include "time_to_pseudo_float_encoder_defines.svh"

module tpf_norm (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tpf_pkg::TICKS_W-1:0]   ticks,
    output tpf_pkg::tpf_norm_res_t        res
);
    import tpf_pkg::*;

    typedef enum logic [1:0] {
        N_IDLE,
        N_SHIFT,
        N_ROUND,
        N_FINAL
    } state_t;

    state_t              state_reg, state_next;
    logic [TICKS_W-1:0]  val_reg, val_next;
    logic [EXP_W-1:0]    exp_reg, exp_next;
    logic                rnd_reg, rnd_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic                done_reg, done_next;

    logic                above_limit;
    logic [FRAC_BITS:0]  rounded;

    assign above_limit = |val_reg[TICKS_W-1:FRAC_BITS];
    assign rounded     = val_reg[FRAC_BITS:0] + (FRAC_BITS + 1)'(1);

    always_comb
    begin
        state_next = state_reg;
        val_next   = val_reg;
        exp_next   = exp_reg;
        rnd_next   = rnd_reg;
        code_next  = code_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    val_next   = ticks;
                    exp_next   = '0;
                    rnd_next   = 1'b0;
                    state_next = N_SHIFT;
                end
            end
            N_SHIFT:
            begin
                if (above_limit)
                begin
                    // The round bit is the one dropped by the latest shift only.
                    rnd_next = val_reg[ROUND_POS];
                    val_next = val_reg >> SHIFT_STEP;
                    exp_next = exp_reg + EXP_W'(1);
                end
                else
                begin
                    state_next = N_ROUND;
                end
            end
            N_ROUND:
            begin
                if (rnd_reg)
                begin
                    if (rounded[FRAC_BITS])
                    begin
                        val_next = TICKS_W'(rounded >> SHIFT_STEP);
                        exp_next = exp_reg + EXP_W'(1);
                    end
                    else
                    begin
                        val_next = TICKS_W'(rounded);
                    end
                end
                state_next = N_FINAL;
            end
            N_FINAL:
            begin
                if (exp_reg > EXP_W'(MAX_EXP))
                begin
                    code_next = '1;
                end
                else
                begin
                    code_next = {exp_reg[EXP_FIELD_W-1:0], val_reg[FRAC_BITS-1:0]};
                end
                done_next  = 1'b1;
                state_next = N_IDLE;
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
            val_reg   <= '0;
            exp_reg   <= '0;
            rnd_reg   <= 1'b0;
            code_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            val_reg   <= val_next;
            exp_reg   <= exp_next;
            rnd_reg   <= rnd_next;
            code_reg  <= code_next;
        end
    end

    assign res.done = done_reg;
    assign res.code = code_reg;

    `TPF_ASSERT_SAME(a_round_normalized, state_reg == N_ROUND, !above_limit)
    `TPF_ASSERT_SAME(a_start_when_idle, start, state_reg == N_IDLE)
    `TPF_ASSERT_SAME(a_done_back_idle, done_reg, state_reg == N_IDLE)

endmodule

>>> src/time_to_pseudo_float_encoder.sv
// ---------------------------------------------------------------------------
// time_to_pseudo_float_encoder
// Compresses a seconds/microseconds interval into a 16-bit pseudo-float
// code with a 3-bit base-8 exponent, saturating at all ones.
// ---------------------------------------------------------------------------
//  channel   handshake            payload
//  input     in_valid, in_ready   seconds[31:0], microseconds[19:0]
//  output    out_valid, out_ready code[15:0]
//
// A request passes the scaler, then k (0 to 9) base-8 shifts in the normalizer
// loop, then rounding and the final step, on its way to the result register.
// The scaler's two multiply steps share its multiplier; a sum step follows.
// in_ready is high only while no request is in flight; a finished result
// waits in the output register, so a new request is taken while it stalls.
// A result that finds the output register still full waits in the sequencer.
// Reset clears all control state; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "time_to_pseudo_float_encoder_defines.svh"

module time_to_pseudo_float_encoder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tpf_pkg::SEC_W-1:0]    seconds,
    input  logic [tpf_pkg::USEC_W-1:0]   microseconds,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tpf_pkg::CODE_W-1:0]   code
);
    import tpf_pkg::*;

    typedef enum logic [1:0] {
        T_IDLE,
        T_SCALE,
        T_NORM,
        T_HOLD
    } state_t;

    state_t             state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]  code_reg, code_next;

    logic               in_fire;
    logic               slot_free;
    tpf_scale_res_t     scale_res;
    tpf_norm_res_t      norm_res;

    assign in_ready  = (state_reg == T_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    tpf_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (in_fire),
        .seconds      (seconds),
        .microseconds (microseconds),
        .res          (scale_res)
    );

    tpf_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scale_res.done),
        .ticks (scale_res.ticks),
        .res   (norm_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg) inside
            T_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = T_SCALE;
                end
            end
            T_SCALE:
            begin
                if (scale_res.done)
                begin
                    state_next = T_NORM;
                end
            end
            T_NORM, T_HOLD:
            begin
                // The normalizer keeps its code until the next start.
                if ((norm_res.done || state_reg == T_HOLD) && slot_free)
                begin
                    code_next      = norm_res.code;
                    out_valid_next = 1'b1;
                    state_next     = T_IDLE;
                end
                else if (norm_res.done)
                begin
                    state_next = T_HOLD;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
            code_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            code_reg      <= code_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign code      = code_reg;

    `TPF_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready)
    `TPF_ASSERT_SAME(a_scale_done_state, scale_res.done, state_reg == T_SCALE)
    `TPF_ASSERT_SAME(a_norm_done_state, norm_res.done, state_reg == T_NORM)

endmodule

>>> tb/time_to_pseudo_float_encoder_tb.sv
// ---------------------------------------------------------------------------
// time_to_pseudo_float_encoder_tb
// Drives seconds/microseconds requests through the encoder, predicts each
// 16-bit pseudo-float code independently, and checks the results in order.
// The run covers boundary intervals and random traffic under several
// idle and stall mixes, plus one long output stall.
// ---------------------------------------------------------------------------
module time_to_pseudo_float_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tpf_pkg::*;

    localparam int RANDOM_REQUESTS = 700;
    localparam int PHASE_COUNT     = 5;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 40;

    // Expected codes of accepted requests, oldest first.
    class code_scoreboard;
        logic [CODE_W-1:0] expected_codes[$];
        int                mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        task report_mismatch(input string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatch_count++;
        endtask

        function logic [CODE_W-1:0] encode_interval(input logic [SEC_W-1:0] secs,
                                                     input logic [USEC_W-1:0] usecs);
            longint unsigned ticks;
            longint unsigned tick_len;
            int unsigned     expo;
            bit              round_up;
            tick_len = longint'(USEC_PER_SEC) / longint'(TICK_RATE);
            ticks    = longint'(secs) * longint'(TICK_RATE);
            expo     = 0;
            round_up = 1'b0;
            if (usecs != '0 && tick_len != 0)
                ticks += longint'(usecs) / tick_len;
            while (ticks >= (64'd1 << FRAC_BITS))
            begin
                expo++;
                round_up = ticks[ROUND_POS];
                ticks    = ticks >> SHIFT_STEP;
            end
            if (round_up)
            begin
                ticks++;
                if (ticks >= (64'd1 << FRAC_BITS))
                begin
                    ticks = ticks >> SHIFT_STEP;
                    expo++;
                end
            end
            if (expo > MAX_EXP)
                return '1;
            return CODE_W'((expo << FRAC_BITS) + ticks);
        endfunction

        function void note_request(input logic [SEC_W-1:0] secs,
                                   input logic [USEC_W-1:0] usecs);
            expected_codes.push_back(encode_interval(secs, usecs));
        endfunction

        task check_result(input logic [CODE_W-1:0] got);
            logic [CODE_W-1:0] want;
            if (expected_codes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected code %h", got));
                return;
            end
            want = expected_codes.pop_front();
            if (got !== want)
                report_mismatch($sformatf("code %h, expected %h", got, want));
        endtask

        function int pending();
            return expected_codes.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [SEC_W-1:0]   seconds;
    logic [USEC_W-1:0]  microseconds;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [CODE_W-1:0]  code;

    int unsigned        send_idle_pct;
    int unsigned        recv_idle_pct;
    logic               hold_req;
    logic               hold_taken = 1'b0;
    int                 hold_left = 0;

    code_scoreboard     sb;

    time_to_pseudo_float_encoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .seconds      (seconds),
        .microseconds (microseconds),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .code         (code)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    // Result side: random stalls, one long hold-off on request, and checking.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_result(code);
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_taken)
        begin
            out_ready  <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_request(input logic [SEC_W-1:0] secs,
                                input logic [USEC_W-1:0] usecs);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        seconds      <= secs;
        microseconds <= usecs;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(secs, usecs);
    endtask

    task automatic send_random_request();
        logic [SEC_W-1:0]  secs;
        logic [USEC_W-1:0] usecs;
        int unsigned       pick;
        // Spread the magnitude so that every exponent and saturation occur.
        secs = $urandom;
        if ($urandom_range(9) != 0)
            secs = secs >> $urandom_range(31);
        pick = $urandom_range(99);
        if (pick < 15)
            usecs = '0;
        else if (pick < 30)
            usecs = USEC_W'($urandom);
        else
            usecs = USEC_W'($urandom_range(USEC_PER_SEC - 1));
        send_request(secs, usecs);
    endtask

    initial
    begin
        int drain_cycles;
        sb            = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        seconds      <= '0;
        microseconds <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Boundary intervals: no shift, first shift, rounding, rounding
        // that renormalizes, saturation after rounding and by size,
        // out-of-range microseconds.
        send_request(32'd0, 20'd0);
        send_request(32'd0, 20'd1);
        send_request(32'd0, 20'd999999);
        send_request(32'd127, 20'd999999);
        send_request(32'd128, 20'd0);
        send_request(32'd128, 20'd62500);
        send_request(32'd128, 20'd78125);
        send_request(32'd1023, 20'd937500);
        send_request(32'd1023, 20'd921875);
        send_request(32'h0FFF_FFFF, 20'd999999);
        send_request(32'h1000_0000, 20'd0);
        send_request(32'hFFFF_FFFF, 20'd0);
        send_request(32'hFFFF_FFFF, 20'hFFFFF);
        send_request(32'd0, 20'd1000000);
        send_request(32'd0, 20'hFFFFF);
        send_request(32'd5, 20'd15624);
        send_request(32'd5, 20'd15625);
        send_request(32'hAAAA_AAAA, 20'h55555);
        send_request(32'h5555_5555, 20'hAAAAA);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 58;
                    recv_idle_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 58;
                end
                3:
                begin
                    send_idle_pct = 25;
                    recv_idle_pct = 25;
                end
                default:
                begin
                    // The sender keeps offering through a long output stall.
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_req      = 1'b1;
                end
            endcase
            for (int n = 0; n < RANDOM_REQUESTS / PHASE_COUNT; n++)
                send_random_request();
        end
        in_valid <= 1'b0;

        drain_cycles = 0;
        while (sb.pending() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d codes never arrived", sb.pending()));

        if (sb.mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/tpf_pkg.sv
src/tpf_scale.sv
src/tpf_norm.sv
src/time_to_pseudo_float_encoder.sv
tb/time_to_pseudo_float_encoder_tb.sv
